@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the digit histogram vote block.
// Define ASSERT_OFF to compile all checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/dhv_pkg.sv @@
// Package for the digit histogram vote block: fixed field widths, codes and
// the control bundle between the sequencer and the vote unit. No dependencies.
package dhv_pkg;

    // Fixed field widths
    localparam int MODE_W    = 2;
    localparam int LEN_W     = 4;
    localparam int CHAR_W    = 8;
    localparam int CELL_W    = 4;
    localparam int SAMPLE_W  = 4;
    localparam int IN_DATA_W  = 24;  // 20 bits of fields, padded to whole bytes
    localparam int OUT_DATA_W = 24;  // 20 bits of fields, padded to whole bytes
    localparam int OUT_USER_W = 2;

    // ASCII and message constants
    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
    localparam logic [LEN_W-1:0]  PAIR_MIN_LEN = 4'd3;

    // Placement modes
    localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIDDLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_MIDDLE;

    // Input actions
    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Grid cell indexes
    localparam int GRID_TL = 0;
    localparam int GRID_TR = 1;
    localparam int GRID_BL = 2;
    localparam int GRID_BR = 3;

    // Per-cycle control of the shared compare/bump unit
    typedef struct packed {
        logic eval;   // a histogram entry is presented this cycle
        logic first;  // entry 0 of the sweep: restart the running max
        logic bump;   // this entry is the voted digit: add one, saturating
    } eval_ctl_t;

endpackage

@@ rtl/dhv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dhv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dhv_vote_unit.sv @@
// Shared saturating increment and running argmax used by every histogram sweep.
// Depends on dhv_pkg (eval_ctl_t).
module dhv_vote_unit
    import dhv_pkg::*;
#(
    parameter int CNT_W = 16,
    parameter int IDX_W = 3
) (
    input  logic             aclk,
    input  eval_ctl_t        ctl,
    input  logic [IDX_W-1:0] idx,
    input  logic [CNT_W-1:0] value_in,
    output logic [CNT_W-1:0] value_out,
    output logic [IDX_W-1:0] best_idx
);

    logic [CNT_W-1:0] best_val_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             take;

    // saturating bump of the voted entry
    assign value_out = (ctl.bump && (value_in != '1)) ? value_in + CNT_W'(1) : value_in;

    // strict greater: the lowest index keeps ties
    assign take = ctl.first || (value_out > best_val_reg);

    always_ff @(posedge aclk) begin
        if (ctl.eval && take) begin
            best_val_reg <= value_out;
            best_idx_reg <= idx;
        end
    end

    assign best_idx = best_idx_reg;

endmodule

@@ rtl/digit_histogram_vote_core.sv @@
// Digit histogram vote core: pair and target histograms, argmax vote, 2x2 grid.
// Depends on dhv_pkg, dhv_ram, dhv_vote_unit and assert_macros.svh.
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  ---------+-----------+------------------------------------------+---------------------
//  s_       | in        | msg_len, first_char, third_char, pad     | action
//  m_       | out       | tl, tr, bl, br cells, target_digit, pad  | target_ready, bad_digit
//  cfg_     | in        | cfg_data = placement_mode                | -
//
// A pair message sweeps both pair histograms, a short message sweeps the target
// histogram, and a clear action goes straight to the result. Each sweep takes one
// entry per cycle through the count RAM's single read port and the shared vote unit.
// Reset (aresetn low, synchronous) empties all histograms via valid bits. s_tready
// is high only when idle; a result waiting on m_tready holds the last step of the
// next item.
`include "assert_macros.svh"

module digit_histogram_vote_core
    import dhv_pkg::*;
#(
    parameter int NUM_CLASSES    = 8,
    parameter int TARGET_SAMPLES = 10,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] msg_len, [11:4] first_char,
                                             // [19:12] third_char, [23:20] zero
    input  logic                  s_tuser,   // [0] action
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] cell_top_left, [7:4] cell_top_right,
                                             // [11:8] cell_bottom_left,
                                             // [15:12] cell_bottom_right,
                                             // [19:16] target_digit, [23:20] zero
    output logic [OUT_USER_W-1:0] m_tuser,   // [0] target_ready, [1] bad_digit
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MODE_W-1:0]     cfg_data
);

    localparam int NC    = NUM_CLASSES;
    localparam int DEPTH = 3 * NC;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NC);
    localparam int CW    = $clog2(NC + 1);
    localparam logic [AW-1:0] BASE_P1  = AW'(NC);
    localparam logic [AW-1:0] BASE_TGT = AW'(2 * NC);
    localparam logic [CHAR_W-1:0] DIG_LO = ASCII_ZERO + CHAR_W'(1);
    localparam logic [CHAR_W-1:0] DIG_HI = ASCII_ZERO + CHAR_W'(NC);

    typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_FINISH} state_t;
    typedef enum logic [1:0] {BANK_P0, BANK_P1, BANK_TGT} bank_t;

    // control state
    state_t               state_reg, state_next;
    bank_t                bank_reg, bank_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 is_clear_reg, is_clear_next;
    logic [DEPTH-1:0]     vld_reg, vld_next;
    logic [SAMPLE_W-1:0]  sample_cnt_reg, sample_cnt_next;
    logic [CELL_W-1:0]    target_win_reg, target_win_next;
    logic [CELL_W-1:0]    grid_reg [4];
    logic [CELL_W-1:0]    grid_next [4];
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // payload
    logic [IW-1:0]         dig0_reg, dig0_next, dig1_reg, dig1_next;
    logic                  hit0_reg, hit0_next, hit1_reg, hit1_next;
    logic                  bad_reg, bad_next;
    logic [CELL_W-1:0]     win0_reg, win0_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0] m_tuser_reg, m_tuser_next;

    // datapath signals
    logic [LEN_W-1:0]       in_len;
    logic [CHAR_W-1:0]      in_c0, in_c1;
    logic                   in_hit0, in_hit1;
    logic [IW-1:0]          in_dig0, in_dig1;
    logic                   s_accept, out_free;
    logic [AW-1:0]          base, rd_addr, ev_addr;
    logic                   rd_en, ev_on;
    logic [IW-1:0]          ev_idx, cur_dig;
    logic                   cur_hit;
    logic [COUNT_WIDTH-1:0] rd_data, ev_value, upd_value;
    logic [IW-1:0]          best_idx;
    logic [CELL_W-1:0]      win_cur;
    logic [SAMPLE_W-1:0]    sample_inc;
    eval_ctl_t              ev_ctl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // field unpack and digit decode
    assign in_len  = s_tdata[3:0];
    assign in_c0   = s_tdata[11:4];
    assign in_c1   = s_tdata[19:12];
    assign in_hit0 = (in_c0 >= DIG_LO) && (in_c0 <= DIG_HI);
    assign in_hit1 = (in_c1 >= DIG_LO) && (in_c1 <= DIG_HI);
    assign in_dig0 = IW'(in_c0 - DIG_LO);
    assign in_dig1 = IW'(in_c1 - DIG_LO);

    // sweep addressing: read entry cnt, evaluate entry cnt-1
    always_comb begin
        unique case (bank_reg)
            BANK_P0:  base = '0;
            BANK_P1:  base = BASE_P1;
            BANK_TGT: base = BASE_TGT;
            default:  base = '0;
        endcase
    end

    assign rd_en   = (state_reg == ST_SWEEP) && (cnt_reg < CW'(NC));
    assign rd_addr = base + AW'(cnt_reg);
    assign ev_on   = (state_reg == ST_SWEEP) && (cnt_reg != '0);
    assign ev_idx  = IW'(cnt_reg - CW'(1));
    assign ev_addr = base + AW'(ev_idx);
    assign cur_dig = (bank_reg == BANK_P1) ? dig1_reg : dig0_reg;
    assign cur_hit = (bank_reg == BANK_P1) ? hit1_reg : hit0_reg;
    assign ev_value = vld_reg[ev_addr] ? rd_data : '0;

    assign ev_ctl.eval  = ev_on;
    assign ev_ctl.first = ev_on && (ev_idx == '0);
    assign ev_ctl.bump  = ev_on && cur_hit && (ev_idx == cur_dig);

    dhv_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_counts (
        .aclk    (aclk),
        .wr_en   (ev_ctl.bump),
        .wr_addr (ev_addr),
        .wr_data (upd_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dhv_vote_unit #(
        .CNT_W (COUNT_WIDTH),
        .IDX_W (IW)
    ) u_vote (
        .aclk      (aclk),
        .ctl       (ev_ctl),
        .idx       (ev_idx),
        .value_in  (ev_value),
        .value_out (upd_value),
        .best_idx  (best_idx)
    );

    // winner digit, kept to the cell width
    assign win_cur    = CELL_W'({1'b0, best_idx} + (IW + 1)'(1));
    assign sample_inc = sample_cnt_reg + SAMPLE_W'(1);

    // sequencer and next-state logic
    always_comb begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        cnt_next        = cnt_reg;
        is_clear_next   = is_clear_reg;
        vld_next        = vld_reg;
        sample_cnt_next = sample_cnt_reg;
        target_win_next = target_win_reg;
        grid_next       = grid_reg;
        mode_next       = mode_reg;
        m_tvalid_next   = m_tvalid_reg;
        dig0_next       = dig0_reg;
        dig1_next       = dig1_reg;
        hit0_next       = hit0_reg;
        hit1_next       = hit1_reg;
        bad_next        = bad_reg;
        win0_next       = win0_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (cfg_valid) begin
            mode_next = cfg_data;
        end

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // entry written back by the sweep becomes valid
        if (ev_ctl.bump) begin
            vld_next[ev_addr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    dig0_next = in_dig0;
                    dig1_next = in_dig1;
                    hit0_next = in_hit0;
                    hit1_next = in_hit1;
                    cnt_next  = '0;
                    if (s_tuser == ACT_CLEAR) begin
                        // empty both pair histograms at once
                        for (int i = 0; i < 2 * NC; i++) begin
                            vld_next[i] = 1'b0;
                        end
                        is_clear_next = 1'b1;
                        bad_next      = 1'b0;
                        state_next    = ST_FINISH;
                    end else if (in_len >= PAIR_MIN_LEN) begin
                        is_clear_next = 1'b0;
                        bad_next      = !in_hit0 || !in_hit1;
                        bank_next     = BANK_P0;
                        state_next    = ST_SWEEP;
                    end else begin
                        is_clear_next = 1'b0;
                        bad_next      = !in_hit0;
                        bank_next     = BANK_TGT;
                        state_next    = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP: begin
                // first cycle of the second pair sweep: first winner is settled
                if (bank_reg == BANK_P1 && cnt_reg == '0) begin
                    win0_next = win_cur;
                end
                if (cnt_reg == CW'(NC)) begin
                    cnt_next = '0;
                    if (bank_reg == BANK_P0) begin
                        bank_next = BANK_P1;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_tuser_next = {bad_reg, 1'b0};
                    if (!is_clear_reg) begin
                        if (bank_reg == BANK_P1) begin
                            // place the two pair winners
                            case (mode_reg)
                                MODE_LEFT: begin
                                    grid_next[GRID_TR] = win0_reg;
                                    grid_next[GRID_TL] = win_cur;
                                end
                                MODE_MIDDLE: begin
                                    grid_next[GRID_TL] = win0_reg;
                                    grid_next[GRID_BL] = win_cur;
                                end
                                MODE_RIGHT: begin
                                    grid_next[GRID_BL] = win0_reg;
                                    grid_next[GRID_BR] = win_cur;
                                end
                                default: ;
                            endcase
                        end else begin
                            // target round bookkeeping
                            if (sample_inc >= SAMPLE_W'(TARGET_SAMPLES)) begin
                                target_win_next = win_cur;
                                sample_cnt_next = '0;
                                m_tuser_next    = {bad_reg, 1'b1};
                            end else begin
                                sample_cnt_next = sample_inc;
                            end
                        end
                    end
                    m_tdata_next  = {4'b0000, target_win_next,
                                     grid_next[GRID_BR], grid_next[GRID_BL],
                                     grid_next[GRID_TR], grid_next[GRID_TL]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bank_reg       <= BANK_P0;
            cnt_reg        <= '0;
            is_clear_reg   <= 1'b0;
            vld_reg        <= '0;
            sample_cnt_reg <= '0;
            target_win_reg <= '0;
            grid_reg       <= '{default: '0};
            mode_reg       <= MODE_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            cnt_reg        <= cnt_next;
            is_clear_reg   <= is_clear_next;
            vld_reg        <= vld_next;
            sample_cnt_reg <= sample_cnt_next;
            target_win_reg <= target_win_next;
            grid_reg       <= grid_next;
            mode_reg       <= mode_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dig0_reg    <= dig0_next;
        dig1_reg    <= dig1_next;
        hit0_reg    <= hit0_next;
        hit1_reg    <= hit1_next;
        bad_reg     <= bad_next;
        win0_reg    <= win0_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `ASSERT_IMPLIES(a_round_bound, aclk, aresetn, 1'b1, sample_cnt_reg < SAMPLE_W'(TARGET_SAMPLES))
    `ASSERT_IMPLIES(a_ready_resets_round, aclk, aresetn, m_tvalid_reg && m_tuser_reg[0], sample_cnt_reg == '0)
    `ASSERT_IMPLIES(a_winner_range, aclk, aresetn, m_tvalid_reg, (m_tdata_reg[3:0] <= NC) && (m_tdata_reg[7:4] <= NC) && (m_tdata_reg[11:8] <= NC) && (m_tdata_reg[15:12] <= NC) && (m_tdata_reg[19:16] <= NC))
    `ASSERT_NEXT(a_sweep_start, aclk, aresetn, s_tvalid && s_tready && (s_tuser == ACT_PROCESS), (state_reg == ST_SWEEP) && (cnt_reg == '0))

endmodule
